### hdl/flpw_pkg.sv
// ----------------------------------------------------------------------------
// flpw_pkg
// Shared types, codes and helpers of the four-level page walker.
// ----------------------------------------------------------------------------
`default_nettype none

package flpw_pkg;

    // Default number of 512-entry tables held in the store
    localparam int FRAMES_DEFAULT = 8;

    localparam int ENTRY_W     = 64;
    localparam int FRAME_W     = 32;
    localparam int VA_W        = 48;
    localparam int WADDR_W     = 12;
    localparam int IDX_W       = 9;
    localparam int LEVEL_W     = 2;
    localparam int FAIL_W      = 3;
    localparam int UPOS_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Entry flag positions and frame field
    localparam int PRESENT_BIT = 0;
    localparam int HUGE_BIT    = 7;
    localparam int FRAME_LSB   = 12;
    localparam int FRAME_MSB   = FRAME_LSB + FRAME_W - 1;

    // Item kinds
    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_USER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_BIT_POS = 2'd2;

    // Walk levels, counted from zero (level 1 of the walk is LVL_TOP)
    localparam logic [LEVEL_W-1:0] LVL_TOP  = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_DIR  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_LEAF = 2'd3;

    typedef struct packed {
        logic [FRAME_W-1:0] root_frame;
        logic               require_user;
        logic [UPOS_W-1:0]  user_bit_pos;
    } t_walk_cfg;

    typedef struct packed {
        logic               range_error;
        logic [FAIL_W-1:0]  fail_level;
        logic [FRAME_W-1:0] frame_number;
        logic [ENTRY_W-1:0] entry_value;
        logic               found;
    } t_walk_result;

    // Table index of a virtual address at a given level
    function automatic logic [IDX_W-1:0] level_index(
        input logic [VA_W-1:0]    va,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_TOP:  idx = va[47:39];
            LVL_DIR:  idx = va[38:30];
            LVL_MID:  idx = va[29:21];
            LVL_LEAF: idx = va[20:12];
            default:  idx = va[47:39];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

### hdl/flpw_ram.sv
// ----------------------------------------------------------------------------
// flpw_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module flpw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/flpw_walk.sv
// ----------------------------------------------------------------------------
// flpw_walk
// Item sequencer: table writes, level-by-level walk and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flpw_walk #(
    parameter int FRAMES = flpw_pkg::FRAMES_DEFAULT
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_enable,
    input  wire flpw_pkg::t_walk_cfg                        i_cfg,
    input  wire logic                                       i_valid,
    output      logic                                       o_ready,
    input  wire logic                                       i_action,
    input  wire logic [flpw_pkg::WADDR_W-1:0]               i_waddr,
    input  wire logic [flpw_pkg::ENTRY_W-1:0]               i_wdata,
    input  wire logic [flpw_pkg::VA_W-1:0]                  i_va,
    output      logic                                       o_mem_we,
    output      logic [$clog2(FRAMES)+flpw_pkg::IDX_W-1:0]  o_mem_waddr,
    output      logic [flpw_pkg::ENTRY_W-1:0]               o_mem_wdata,
    output      logic                                       o_mem_re,
    output      logic [$clog2(FRAMES)+flpw_pkg::IDX_W-1:0]  o_mem_raddr,
    input  wire logic [flpw_pkg::ENTRY_W-1:0]               i_mem_rdata,
    output      logic                                       o_valid,
    input  wire logic                                       i_ready,
    output      flpw_pkg::t_walk_result                     o_result
);

    import flpw_pkg::*;

    localparam int FW    = $clog2(FRAMES);
    localparam int AW    = FW + IDX_W;
    localparam int DEPTH = FRAMES * (2 ** IDX_W);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [VA_W-1:0]    r_va, n_va;
    logic               r_out_valid, n_out_valid;
    t_walk_result       r_out, n_out;
    t_walk_result       r_res, n_res;

    logic               slot_free;
    logic               accept;
    logic               fin;
    t_walk_result       fin_res;
    logic               entry_ok;
    logic [FRAME_W-1:0] next_frame;

    assign slot_free = !r_out_valid || i_ready;
    assign o_ready   = i_enable && (r_state == ST_IDLE);
    assign accept    = i_valid && o_ready;

    // Entry checks for the level under walk
    always_comb begin
        entry_ok = i_mem_rdata[PRESENT_BIT];
        if (i_cfg.require_user) begin
            if (!i_mem_rdata[i_cfg.user_bit_pos]) begin
                entry_ok = 1'b0;
            end
            if ((r_level == LVL_MID) && i_mem_rdata[HUGE_BIT]) begin
                entry_ok = 1'b0;
            end
        end
    end

    assign next_frame = i_mem_rdata[FRAME_MSB:FRAME_LSB];

    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_va        = r_va;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        fin         = 1'b0;
        fin_res     = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(i_waddr);
        o_mem_wdata = i_wdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_WRITE) begin
                        // drop writes beyond the store
                        o_mem_we = ({20'd0, i_waddr} < 32'(DEPTH));
                        fin      = 1'b1;
                    end else begin
                        n_va    = i_va;
                        n_level = LVL_TOP;
                        if (i_cfg.root_frame >= 32'(FRAMES)) begin
                            fin                 = 1'b1;
                            fin_res.fail_level  = 3'd1;
                            fin_res.range_error = 1'b1;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = {i_cfg.root_frame[FW-1:0],
                                           level_index(i_va, LVL_TOP)};
                            n_state     = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (!entry_ok) begin
                    fin                = 1'b1;
                    fin_res.fail_level = FAIL_W'(r_level) + 3'd1;
                end else if (r_level == LVL_LEAF) begin
                    fin                  = 1'b1;
                    fin_res.found        = 1'b1;
                    fin_res.entry_value  = i_mem_rdata;
                    fin_res.frame_number = next_frame;
                end else if (next_frame >= 32'(FRAMES)) begin
                    fin                 = 1'b1;
                    fin_res.fail_level  = FAIL_W'(r_level) + 3'd2;
                    fin_res.range_error = 1'b1;
                end else begin
                    n_level     = r_level + 2'd1;
                    o_mem_re    = 1'b1;
                    o_mem_raddr = {next_frame[FW-1:0],
                                   level_index(r_va, r_level + 2'd1)};
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Load the output register, or park the result while it is occupied
        if (fin) begin
            if (slot_free) begin
                n_out       = fin_res;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = ST_RESULT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= LVL_TOP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
        r_va  <= n_va;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // A parked result exists only behind an occupied output register
    a_park_behind_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT) |-> r_out_valid)
        else $error("parked result with empty output register");

    // No table read is issued past the leaf level
    a_no_read_past_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_re && (r_state == ST_WALK)) |-> (r_level != LVL_LEAF))
        else $error("table read issued beyond leaf level");

endmodule

`default_nettype wire

### hdl/four_level_page_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_walker
// Four-level page table walker over a local page-table store.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the slave stream. tuser carries the item kind: a
//   write stores one 64-bit entry at a word address, a translate walks the
//   four tables from root_frame for a 48-bit virtual address. Every item
//   yields exactly one result item on the master stream (all zero for a
//   write). Configuration registers are set through the plain write port.
//   Sequence: a write result is loaded into the output register, or parked
//   while that is occupied. A translate issues the root read on acceptance,
//   then one read per further level, each dependent on the last through
//   the single read port of the store, and ends early when a level fails.
//   One item is in work at a time; the next is taken as soon as the
//   sequencer is idle, even while the previous result still waits.
//   Reset: the store is swept to zero one entry per cycle, all FRAMES * 512
//   entries, and no item is accepted until the sweep ends; configuration
//   writes are taken throughout. Configuration returns to its reset values.
//   Stall: a result waits in the output register; a further result is
//   parked in a staging register and input is held off until it moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_walker #(
    parameter int FRAMES = flpw_pkg::FRAMES_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_wen,
    input  wire logic [flpw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [flpw_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Slave stream
    input  wire logic                              i_s_axis_tvalid,
    output      logic                              o_s_axis_tready,
    // tdata, low bit up: table_word_address[11:0], table_word_data[75:12],
    // virt_addr[123:76], zero fill[127:124]
    input  wire logic [127:0]                      i_s_axis_tdata,
    // tuser: action[0]
    input  wire logic                              i_s_axis_tuser,
    // Master stream
    output      logic                              o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // tdata, low bit up: found[0], entry_value[64:1], frame_number[96:65],
    // fail_level[99:97], range_error[100], zero fill[103:101]
    output      logic [103:0]                      o_m_axis_tdata
);

    import flpw_pkg::*;

    localparam int FW    = $clog2(FRAMES);
    localparam int AW    = FW + IDX_W;
    localparam int DEPTH = FRAMES * (2 ** IDX_W);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    // Configuration registers
    t_walk_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.root_frame   <= '0;
            r_cfg.require_user <= 1'b1;
            r_cfg.user_bit_pos <= 6'd4;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_ROOT_FRAME:   r_cfg.root_frame   <= i_cfg_wdata[FRAME_W-1:0];
                CFG_REQUIRE_USER: r_cfg.require_user <= i_cfg_wdata[0];
                CFG_USER_BIT_POS: r_cfg.user_bit_pos <= i_cfg_wdata[UPOS_W-1:0];
                default: begin
                    // ignore writes to unmapped indexes
                end
            endcase
        end
    end

    // Clearing sweep after reset: one store entry per cycle
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Walker sequencer
    logic                walk_we;
    logic [AW-1:0]       walk_waddr;
    logic [ENTRY_W-1:0]  walk_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;
    t_walk_result        walk_res;

    flpw_walk #(
        .FRAMES (FRAMES)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (!r_clr_busy),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .i_waddr     (i_s_axis_tdata[11:0]),
        .i_wdata     (i_s_axis_tdata[75:12]),
        .i_va        (i_s_axis_tdata[123:76]),
        .o_mem_we    (walk_we),
        .o_mem_waddr (walk_waddr),
        .o_mem_wdata (walk_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (walk_res)
    );

    // Store write port: the sweep owns it until it ends
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;

    assign mem_we    = r_clr_busy || walk_we;
    assign mem_waddr = r_clr_busy ? r_clr_addr : walk_waddr;
    assign mem_wdata = r_clr_busy ? '0 : walk_wdata;

    flpw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_m_axis_tdata = {3'b000, walk_res.range_error, walk_res.fail_level,
                             walk_res.frame_number, walk_res.entry_value,
                             walk_res.found};

    // Hold off input for the whole sweep
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!o_s_axis_tready && !walk_we && !mem_re))
        else $error("store accessed during clearing sweep");

    // The sweep ends only after the last entry has been cleared
    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> ($past(r_clr_addr) == CLR_LAST))
        else $error("clearing sweep ended early");

endmodule

`default_nettype wire
